@@ sv/b32d_pkg.sv @@
// Shared types and constants for the Base32 stream decoder.
// Used by every module of the decoder; depends on nothing.
package b32d_pkg;

  localparam int ALPHA_WORDS  = 8;
  localparam int ALPHA_IDX_W  = 3;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int CHARS_PER_W  = 4;
  localparam int CODE_W       = 5;
  localparam int ACC_W        = 7;
  localparam int CNT_W        = 3;

  localparam logic [CFG_DATA_W-1:0] ALPHA_RESET [ALPHA_WORDS] = '{
    32'd1145258561, 32'd1212630597, 32'd1280002633, 32'd1347374669,
    32'd1414746705, 32'd1482118741, 32'd858937945,  32'd926299444
  };

  typedef struct packed {
    logic              valid;
    logic [7:0]        symbol;
    logic              start;
    logic              found;
    logic [CODE_W-1:0] code;
  } cell_t;

endpackage

@@ sv/base32_stream_decoder.sv @@
// Top level of the Base32 stream decoder: a row of lookup cells and the accumulator.
// Depends on b32d_pkg, b32d_cell and b32d_accum.
//
// One character enters per beat on the input channel (symbol, start_of_message)
// under in_valid/in_ready. Each of the eight lookup cells holds one alphabet
// register and passes the character on to its neighbor, marking the lowest
// matching alphabet index. The accumulator appends the 5-bit index and sends a
// byte on the output channel (data_byte, bad_symbol) under out_valid/out_ready
// whenever eight bits are held; an unknown character gives one beat with
// bad_symbol set. A set start_of_message clears the held bits first.
// Throughput is one character per cycle while the receiver keeps taking bytes.
// The character that completes a byte is registered in the first cell, then in
// each of the other seven cells in turn, and then in the output register. When
// the receiver stalls, the output register holds its beat and each cell stage
// fills up behind it, so the input keeps taking characters until the row is
// full. Reset empties the row, clears the held bits and loads the standard
// alphabet. Alphabet registers are written through cfg_write/cfg_index/cfg_data;
// the user must do so only while the decoder is idle, which the block does not
// enforce. Indexes past the last register are ignored.
module base32_stream_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [b32d_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [b32d_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        symbol,
  input  logic                              start_of_message,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        data_byte,
  output logic                              bad_symbol
);

  b32d_pkg::cell_t link  [b32d_pkg::ALPHA_WORDS+1];
  logic            ready [b32d_pkg::ALPHA_WORDS+1];

  always_comb begin
    link[0]        = '0;
    link[0].valid  = in_valid;
    link[0].symbol = symbol;
    link[0].start  = start_of_message;
  end

  assign in_ready = ready[0];

  for (genvar k = 0; k < b32d_pkg::ALPHA_WORDS; k++) begin : g_cell
    b32d_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_id    (b32d_pkg::ALPHA_IDX_W'(k)),
      .cfg_write  (cfg_write),
      .cfg_index  (cfg_index),
      .cfg_data   (cfg_data),
      .din        (link[k]),
      .din_ready  (ready[k]),
      .dout       (link[k+1]),
      .dout_ready (ready[k+1])
    );
  end

  b32d_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .din        (link[b32d_pkg::ALPHA_WORDS]),
    .din_ready  (ready[b32d_pkg::ALPHA_WORDS]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .bad_symbol (bad_symbol)
  );

endmodule

@@ sv/b32d_cell.sv @@
// One lookup cell: holds one alphabet word and compares a passing symbol against it.
// Depends on b32d_pkg.
module b32d_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [b32d_pkg::ALPHA_IDX_W-1:0]     cell_id,
  input  logic                                 cfg_write,
  input  logic [b32d_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [b32d_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  b32d_pkg::cell_t                      din,
  output logic                                 din_ready,
  output b32d_pkg::cell_t                      dout,
  input  logic                                 dout_ready
);

  logic [b32d_pkg::CFG_DATA_W-1:0] alpha_word;
  b32d_pkg::cell_t                 q;
  b32d_pkg::cell_t                 q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_word <= b32d_pkg::ALPHA_RESET[cell_id];
    end else if (cfg_write && cfg_index == b32d_pkg::CFG_INDEX_W'(cell_id)) begin
      alpha_word <= cfg_data;
    end
  end

  always_comb begin
    q_next = din;
    for (int j = b32d_pkg::CHARS_PER_W - 1; j >= 0; j--) begin
      if (!din.found && alpha_word[j*8 +: 8] == din.symbol) begin
        q_next.found = 1'b1;
        q_next.code  = {cell_id, 2'(j)};
      end
    end
  end

  assign din_ready = !q.valid || dout_ready;
  assign dout      = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (din_ready) begin
      q <= q_next;
    end
  end

endmodule

@@ sv/b32d_accum.sv @@
// Bit accumulator and output register: packs 5-bit codes into bytes.
// Depends on b32d_pkg.
module b32d_accum (
  input  logic            clk,
  input  logic            rst,
  input  b32d_pkg::cell_t din,
  output logic            din_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      data_byte,
  output logic            bad_symbol
);

  logic [b32d_pkg::ACC_W-1:0]                 acc;
  logic [b32d_pkg::CNT_W-1:0]                 cnt;
  logic [b32d_pkg::ACC_W-1:0]                 acc_base;
  logic [b32d_pkg::CNT_W-1:0]                 cnt_base;
  logic [b32d_pkg::CNT_W:0]                   sum;
  logic [b32d_pkg::ACC_W+b32d_pkg::CODE_W-1:0] acc_wide;
  logic [b32d_pkg::ACC_W-1:0]                 acc_next;
  logic [b32d_pkg::CNT_W-1:0]                 cnt_next;
  logic [7:0]                                 byte_next;
  logic                                       take;
  logic                                       emit;

  assign din_ready = !out_valid || out_ready;
  assign take      = din.valid && din_ready;

  always_comb begin
    acc_base  = din.start ? '0 : acc;
    cnt_base  = din.start ? '0 : cnt;
    sum       = {1'b0, cnt_base} + (b32d_pkg::CNT_W+1)'(b32d_pkg::CODE_W);
    acc_wide  = {acc_base, din.code};
    byte_next = 8'(acc_wide >> sum[b32d_pkg::CNT_W-1:0]);
    if (din.found) begin
      acc_next = acc_wide[b32d_pkg::ACC_W-1:0]
               & ~({b32d_pkg::ACC_W{1'b1}} << sum[b32d_pkg::CNT_W-1:0]);
      cnt_next = sum[b32d_pkg::CNT_W-1:0];
      emit     = sum[b32d_pkg::CNT_W];
    end else begin
      acc_next = acc_base;
      cnt_next = cnt_base;
      emit     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        acc <= acc_next;
        cnt <= cnt_next;
        if (emit) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      data_byte  <= din.found ? byte_next : 8'h00;
      bad_symbol <= !din.found;
    end
  end

endmodule

@@ sv/b32d_checker.sv @@
// Port-level checks for the Base32 stream decoder, bound to its top level.
// Depends on base32_stream_decoder, whose ports it watches.
module b32d_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [7:0]                        data_byte,
  input logic                              bad_symbol
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(bad_symbol))
    else $error("Stalled output beat changed or dropped.");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_symbol |-> data_byte == 8'h00)
    else $error("Error beat carries a nonzero byte.");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && in_ready)
    else $error("Decoder not empty after reset.");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while the output is free.");

endmodule

bind base32_stream_decoder b32d_checker u_b32d_checker (.*);
